// File: hw/rtl/valu_pkg.sv
// Package: opcodes, widths, channel payloads and command/status types for the 64-bit VM ALU.
`timescale 1ns / 1ps
package valu_pkg;
	localparam int unsigned WordBits = 64;
	localparam int unsigned ModeBits = 5;
	localparam int unsigned AmtBits  = 6;
	localparam int unsigned CntBits  = 7;

	typedef enum logic [ModeBits-1:0] {
		OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3,
		OP_IDIV = 5'd4, OP_MOD = 5'd5, OP_NOT = 5'd6, OP_NEG = 5'd7,
		OP_AND = 5'd8, OP_OR = 5'd9, OP_XOR = 5'd10, OP_SHR = 5'd11,
		OP_SHL = 5'd12, OP_SAR = 5'd13, OP_ROR = 5'd14, OP_ROL = 5'd15,
		OP_PDEP = 5'd16, OP_PEXT = 5'd17, OP_BSWAPW = 5'd18,
		OP_BSWAPD = 5'd19, OP_BSWAPQ = 5'd20, OP_INC = 5'd21, OP_DEC = 5'd22
	} op_t;

	// transaction payloads of the two channels
	typedef struct packed {
		logic [ModeBits-1:0] mode;
		logic [WordBits-1:0] operand_a;
		logic [WordBits-1:0] operand_b;
		logic                has_amount;
	} alu_req_t;

	typedef struct packed {
		logic [WordBits-1:0] result;
		logic                write_back;
		logic                bad_arithmetic;
	} alu_rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture operands of a new transaction
		logic step;      // one iteration (divide bit / mul bit / pdep-pext bit)
		logic finish;    // form the result from the working registers
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic iter;      // captured op needs the iterative loop
		logic last;      // iteration counter at its final step
	} sts_t;
endpackage

// File: hw/rtl/valu_if.sv
// Valid/ready channel interface with a parameterized payload type.
`timescale 1ns / 1ps
interface valu_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/vm_integer_alu_64.sv
// Top level of the 64-bit VM integer ALU: controller plus datapath.
`timescale 1ns / 1ps
//  channel   dir   payload                                       handshake
//  in_ch     in    mode, operand_a, operand_b, has_amount        valid/ready
//  out_ch    out   result, write_back, bad_arithmetic            valid/ready
//
// One transaction at a time. Every op passes through the run, finish and output
// states; mul, div, idiv, mod, pdep and pext run the shared one-bit loop for 64
// iterations in the run state before finish. The next accept comes only after the
// result is taken and the controller has returned to idle.
// arst_n clears the controller only; payload registers are not reset.
// A stalled result holds in the output register; input is refused until taken.
module vm_integer_alu_64 (
	input logic clk,
	input logic arst_n,
	valu_if.sink   in_ch,
	valu_if.source out_ch
);
	import valu_pkg::*;

	cmd_t cmd;
	sts_t sts;

	valu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: payload struct members mirror the field list
	valu_dp u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.mode           (in_ch.data.mode),
		.operand_a      (in_ch.data.operand_a),
		.operand_b      (in_ch.data.operand_b),
		.has_amount     (in_ch.data.has_amount),
		.sts            (sts),
		.result         (out_ch.data.result),
		.write_back     (out_ch.data.write_back),
		.bad_arithmetic (out_ch.data.bad_arithmetic)
	);
endmodule

// File: hw/rtl/valu_ctrl.sv
// Controller state machine: sequences load, iterate, finish and output hold.
`timescale 1ns / 1ps
module valu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  valu_pkg::sts_t sts,
	output valu_pkg::cmd_t cmd
);
	import valu_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN, S_OUT} state_t;
	state_t state_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.step   = (state_q == S_RUN);
		cmd.finish = (state_q == S_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_RUN;
				S_RUN: begin
					if (!sts.iter || sts.last) state_q <= S_FIN;
				end
				S_FIN: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !in_ready)
		else $error("accepting while busy");
	a_fin_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("finish not followed by output");
`endif
endmodule

// File: hw/rtl/valu_dp.sv
// Datapath: operand registers, shared shift-subtract/shift-add loop, result logic.
`timescale 1ns / 1ps
module valu_dp (
	input  logic                               clk,
	input  valu_pkg::cmd_t                     cmd,
	input  logic [valu_pkg::ModeBits-1:0]      mode,
	input  logic [valu_pkg::WordBits-1:0]      operand_a,
	input  logic [valu_pkg::WordBits-1:0]      operand_b,
	input  logic                               has_amount,
	output valu_pkg::sts_t                     sts,
	output logic [valu_pkg::WordBits-1:0]      result,
	output logic                               write_back,
	output logic                               bad_arithmetic
);
	import valu_pkg::*;

	localparam int unsigned W = WordBits;

	logic [ModeBits-1:0] mode_q;
	logic [W-1:0]        a_q, b_q, acc_q, rem_q, quo_q, msk_q;
	logic                hasamt_q, nega_q, negb_q;
	logic [CntBits-1:0]  cnt_q;
	logic [W-1:0]        r_q;
	logic                wb_q, bad_q;

	logic is_div, iter;
	logic [W:0] trial;
	logic [W:0] rem_sh;     // partial remainder can exceed 2^64 (up to 2^65 - 3) before the subtract
	logic [W-1:0] low_bit;
	logic [AmtBits-1:0] amt, rc;
	logic [W-1:0] fin_r;
	logic         fin_wb, fin_bad;
	logic [W-1:0] sar_fill;

	always_comb begin
		is_div = (mode_q == OP_DIV) || (mode_q == OP_IDIV) || (mode_q == OP_MOD);
		iter   = is_div || (mode_q == OP_MUL) || (mode_q == OP_PDEP) ||
		         (mode_q == OP_PEXT);
		sts.iter = iter;
		sts.last = (cnt_q == CntBits'(W - 1));
		rem_sh   = {rem_q, quo_q[W-1]};
		trial    = rem_sh - {1'b0, b_q};
		low_bit  = msk_q & (~msk_q + W'(1));
	end

	// b_q holds |divisor| for divides; quo_q starts as |dividend|, shifts in quotient bits
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode;
			a_q      <= operand_a;
			hasamt_q <= has_amount;
			nega_q   <= (mode == OP_IDIV) && operand_a[W-1];
			negb_q   <= (mode == OP_IDIV) && operand_b[W-1];
			b_q      <= ((mode == OP_IDIV) && operand_b[W-1]) ? -operand_b : operand_b;
			quo_q    <= ((mode == OP_IDIV) && operand_a[W-1]) ? -operand_a : operand_a;
			rem_q    <= '0;
			acc_q    <= '0;
			msk_q    <= operand_b;
			cnt_q    <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + CntBits'(1);
			if (is_div) begin
				if (!trial[W]) begin
					rem_q <= trial[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
			end else if (mode_q == OP_MUL) begin
				if (b_q[cnt_q[AmtBits-1:0]]) acc_q <= acc_q + (a_q << cnt_q[AmtBits-1:0]);
			end else if (mode_q == OP_PDEP) begin
				if (a_q[cnt_q[AmtBits-1:0]]) acc_q <= acc_q | low_bit;
				msk_q <= msk_q ^ low_bit;
			end else begin
				if ((a_q & low_bit) != '0) acc_q[cnt_q[AmtBits-1:0]] <= 1'b1;
				msk_q <= msk_q ^ low_bit;
			end
		end
	end

	always_comb begin
		amt      = b_q[AmtBits-1:0];
		rc       = hasamt_q ? amt : AmtBits'(1);
		sar_fill = (a_q[W-1] && amt != '0) ? ~({W{1'b1}} >> amt) : '0;
		fin_r    = '0;
		fin_wb   = 1'b1;
		fin_bad  = 1'b0;
		case (mode_q)
			OP_ADD:  fin_r = a_q + b_q;
			OP_SUB:  fin_r = a_q - b_q;
			OP_MUL, OP_PDEP, OP_PEXT: fin_r = acc_q;
			OP_DIV, OP_IDIV, OP_MOD: begin
				if (b_q == '0) begin
					fin_wb  = 1'b0;
					fin_bad = 1'b1;
				end else if (mode_q == OP_MOD) begin
					fin_r = rem_q;
				end else begin
					fin_r = (nega_q != negb_q) ? -quo_q : quo_q;
				end
			end
			OP_NOT:  fin_r = ~a_q;
			OP_NEG:  fin_r = -a_q;
			OP_AND:  fin_r = a_q & b_q;
			OP_OR:   fin_r = a_q | b_q;
			OP_XOR:  fin_r = a_q ^ b_q;
			OP_SHR:  fin_r = a_q >> amt;
			OP_SHL:  fin_r = a_q << amt;
			OP_SAR:  fin_r = (a_q >> amt) | sar_fill;
			OP_ROR:  fin_r = (rc == '0) ? a_q : ((a_q >> rc) | (a_q << (W - 32'(rc))));
			OP_ROL:  fin_r = (rc == '0) ? a_q : ((a_q << rc) | (a_q >> (W - 32'(rc))));
			OP_BSWAPW: fin_r = {48'd0, a_q[7:0], a_q[15:8]};
			OP_BSWAPD: fin_r = {32'd0, a_q[7:0], a_q[15:8], a_q[23:16], a_q[31:24]};
			OP_BSWAPQ: fin_r = {a_q[7:0], a_q[15:8], a_q[23:16], a_q[31:24],
			                    a_q[39:32], a_q[47:40], a_q[55:48], a_q[63:56]};
			OP_INC:  fin_r = a_q + W'(1);
			OP_DEC:  fin_r = a_q - W'(1);
			default: fin_wb = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			r_q   <= fin_r;
			wb_q  <= fin_wb;
			bad_q <= fin_bad;
		end
	end

	assign result         = r_q;
	assign write_back     = wb_q;
	assign bad_arithmetic = bad_q;

`ifndef SYNTHESIS
	a_flag_excl: assert property (@(posedge clk) cmd.finish |=> !(bad_q && wb_q))
		else $error("fault with write-back");
	a_bad_zero: assert property (@(posedge clk) cmd.finish |=> (!bad_q || r_q == '0))
		else $error("fault result not zero");
	a_cnt_step: assert property (@(posedge clk) cmd.step |=> cnt_q == $past(cnt_q) + CntBits'(1))
		else $error("iteration counter skipped");
`endif
endmodule

// File: dv/vm_integer_alu_64_test.sv
// Self-checking testbench for the 64-bit VM integer ALU: directed table, then random traffic.
`timescale 1ns / 1ps
module vm_integer_alu_64_test;
	import valu_pkg::*;

	// one row of the directed table: typed answer only where it is obvious
	typedef struct {
		alu_req_t req;
		bit       typed;
		alu_rsp_t rsp;
	} vector_t;

	// opcodes past the last defined one
	localparam logic [ModeBits-1:0] MODE_UNUSED_LO = 5'd23;
	localparam logic [ModeBits-1:0] MODE_UNUSED_HI = 5'd31;
	localparam logic [WordBits-1:0] WORD_ONES = '1;
	localparam logic [WordBits-1:0] WORD_MIN  = 64'h8000_0000_0000_0000;
	localparam logic [WordBits-1:0] WORD_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int RANDOM_ITEMS = 1800;
	localparam int IDLE_PCT     = 37;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int DRAIN_CYCLES = 80;

	logic clk;
	logic arst_n;

	valu_if #(.payload_t(alu_req_t)) in_ch  (clk);
	valu_if #(.payload_t(alu_rsp_t)) out_ch (clk);

	vm_integer_alu_64 DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	alu_rsp_t pending_rsp_q[$];
	vector_t  directed_rows[$];
	int       error_count;
	int       sent_count;
	int       rsp_count;
	int       fault_count;
	int       cycle_count;
	bit       idle_enable;
	bit       stim_done;

	// free-running clock, 2 ns period
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Predictor. Everything computed on unsigned 64-bit vectors; signed
	// divide works on magnitudes so MIN / -1 simply wraps back to MIN.
	// ---------------------------------------------------------------------
	function automatic logic [WordBits-1:0] bit_deposit(logic [WordBits-1:0] src,
			logic [WordBits-1:0] mask);
		logic [WordBits-1:0] r;
		int k;
		r = '0;
		k = 0;
		for (int i = 0; i < WordBits; i++) begin
			if (mask[i]) begin
				r[i] = src[k];
				k++;
			end
		end
		return r;
	endfunction

	function automatic logic [WordBits-1:0] bit_extract(logic [WordBits-1:0] src,
			logic [WordBits-1:0] mask);
		logic [WordBits-1:0] r;
		int k;
		r = '0;
		k = 0;
		for (int i = 0; i < WordBits; i++) begin
			if (mask[i]) begin
				r[k] = src[i];
				k++;
			end
		end
		return r;
	endfunction

	// reverse the low nbytes bytes, upper bytes cleared
	function automatic logic [WordBits-1:0] swap_low_bytes(logic [WordBits-1:0] v, int nbytes);
		logic [WordBits-1:0] r;
		r = '0;
		for (int i = 0; i < nbytes; i++)
			r[8*(nbytes-1-i) +: 8] = v[8*i +: 8];
		return r;
	endfunction

	function automatic alu_rsp_t alu_predict(alu_req_t req);
		alu_rsp_t rsp;
		logic [WordBits-1:0] a, b, ma, mb, q;
		logic [AmtBits-1:0]  amt, rot;
		a   = req.operand_a;
		b   = req.operand_b;
		amt = b[AmtBits-1:0];
		rot = req.has_amount ? amt : AmtBits'(1);
		rsp = '{result: '0, write_back: 1'b1, bad_arithmetic: 1'b0};
		case (req.mode)
			OP_ADD:    rsp.result = a + b;
			OP_SUB:    rsp.result = a - b;
			OP_MUL:    rsp.result = a * b;
			OP_DIV, OP_IDIV, OP_MOD: begin
				if (b == '0) begin
					rsp.write_back     = 1'b0;
					rsp.bad_arithmetic = 1'b1;
				end else if (req.mode == OP_DIV) begin
					rsp.result = a / b;
				end else if (req.mode == OP_MOD) begin
					rsp.result = a % b;
				end else begin
					ma = a[WordBits-1] ? -a : a;
					mb = b[WordBits-1] ? -b : b;
					q  = ma / mb;
					rsp.result = (a[WordBits-1] != b[WordBits-1]) ? -q : q;
				end
			end
			OP_NOT:    rsp.result = ~a;
			OP_NEG:    rsp.result = -a;
			OP_AND:    rsp.result = a & b;
			OP_OR:     rsp.result = a | b;
			OP_XOR:    rsp.result = a ^ b;
			OP_SHR:    rsp.result = a >> amt;
			OP_SHL:    rsp.result = a << amt;
			OP_SAR:    rsp.result = $unsigned($signed(a) >>> amt);
			// shift by 64 yields zero, so a zero count falls out unchanged
			OP_ROR:    rsp.result = (a >> rot) | (a << (7'd64 - rot));
			OP_ROL:    rsp.result = (a << rot) | (a >> (7'd64 - rot));
			OP_PDEP:   rsp.result = bit_deposit(a, b);
			OP_PEXT:   rsp.result = bit_extract(a, b);
			OP_BSWAPW: rsp.result = swap_low_bytes(a, 2);
			OP_BSWAPD: rsp.result = swap_low_bytes(a, 4);
			OP_BSWAPQ: rsp.result = swap_low_bytes(a, 8);
			OP_INC:    rsp.result = a + WordBits'(1);
			OP_DEC:    rsp.result = a - WordBits'(1);
			default:   rsp.write_back = 1'b0;
		endcase
		return rsp;
	endfunction

	// ---------------------------------------------------------------------
	// Directed table
	// ---------------------------------------------------------------------
	function automatic void add_row(logic [ModeBits-1:0] mode, logic [WordBits-1:0] a,
			logic [WordBits-1:0] b, logic ha, bit typed = 0,
			logic [WordBits-1:0] res = '0, logic wb = 1'b1, logic bad = 1'b0);
		vector_t row;
		row.req   = '{mode: mode, operand_a: a, operand_b: b, has_amount: ha};
		row.typed = typed;
		row.rsp   = '{result: res, write_back: wb, bad_arithmetic: bad};
		directed_rows.push_back(row);
	endfunction

	function automatic void build_directed();
		// wraparound extremes
		add_row(OP_ADD, WORD_ONES, 64'd1, 1'b0, 1, '0);
		add_row(OP_SUB, '0, 64'd1, 1'b1, 1, WORD_ONES);
		add_row(OP_MUL, WORD_ONES, WORD_ONES, 1'b0, 1, 64'd1);
		// divide by zero: flag up, nothing written
		add_row(OP_DIV, WORD_ONES, '0, 1'b0, 1, '0, 1'b0, 1'b1);
		add_row(OP_IDIV, WORD_MIN, '0, 1'b1, 1, '0, 1'b0, 1'b1);
		add_row(OP_MOD, 64'd5, '0, 1'b0, 1, '0, 1'b0, 1'b1);
		// signed overflow wraps, truncation toward zero
		add_row(OP_IDIV, WORD_MIN, WORD_ONES, 1'b0, 1, WORD_MIN);
		add_row(OP_IDIV, -64'sd7, 64'd2, 1'b0, 1, -64'sd3);
		add_row(OP_DIV, WORD_ONES, 64'd1, 1'b0, 1, WORD_ONES);
		add_row(OP_MOD, WORD_ONES, WORD_MAX, 1'b0, 1, 64'd1);
		add_row(OP_NOT, '0, WORD_ONES, 1'b1, 1, WORD_ONES);
		add_row(OP_NEG, WORD_MIN, '0, 1'b0, 1, WORD_MIN);
		add_row(OP_AND, WORD_ONES, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0);
		add_row(OP_OR, WORD_MIN, 64'd1, 1'b0);
		add_row(OP_XOR, WORD_ONES, WORD_MAX, 1'b0, 1, WORD_MIN);
		// shift amounts only use their low six bits
		add_row(OP_SHR, WORD_ONES, 64'd127, 1'b0, 1, 64'd1);
		add_row(OP_SHL, WORD_ONES, 64'd64, 1'b0, 1, WORD_ONES);
		add_row(OP_SAR, WORD_MIN, 64'd63, 1'b0, 1, WORD_ONES);
		// rotate: zero count, default count of one, largest count
		add_row(OP_ROR, 64'h1234_5678_9ABC_DEF0, 64'd64, 1'b1, 1,
			64'h1234_5678_9ABC_DEF0);
		add_row(OP_ROL, WORD_MIN, 64'd5, 1'b0, 1, 64'd1);
		add_row(OP_ROR, 64'd1, 64'd63, 1'b1, 1, 64'd2);
		add_row(OP_PDEP, WORD_ONES, 64'hA5A5_0000_FFFF_0001, 1'b0);
		add_row(OP_PEXT, 64'hDEAD_BEEF_CAFE_F00D, WORD_ONES, 1'b0, 1,
			64'hDEAD_BEEF_CAFE_F00D);
		add_row(OP_BSWAPW, 64'h1122_3344_5566_7788, '0, 1'b0, 1, 64'h8877);
		add_row(OP_BSWAPD, 64'h1122_3344_5566_7788, '0, 1'b0);
		add_row(OP_BSWAPQ, 64'h1122_3344_5566_7788, '0, 1'b0, 1,
			64'h8877_6655_4433_2211);
		add_row(OP_INC, WORD_MAX, '0, 1'b0, 1, WORD_MIN);
		add_row(OP_DEC, '0, '0, 1'b0, 1, WORD_ONES);
		// undefined opcodes: no write, no flag
		add_row(MODE_UNUSED_LO, WORD_ONES, WORD_ONES, 1'b1, 1, '0, 1'b0, 1'b0);
		add_row(MODE_UNUSED_HI, WORD_ONES, '0, 1'b0, 1, '0, 1'b0, 1'b0);
	endfunction

	// ---------------------------------------------------------------------
	// Random stimulus helpers
	// ---------------------------------------------------------------------
	function automatic logic [WordBits-1:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return WORD_ONES;
			2:       return WORD_MIN;
			3:       return WORD_MAX;
			4:       return WordBits'($urandom_range(0, 200));
			5:       return -WordBits'($urandom_range(1, 200));
			6:       return WordBits'($urandom) << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic alu_req_t random_req();
		alu_req_t req;
		if ($urandom_range(0, 99) < 4)
			req.mode = ModeBits'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
		else
			req.mode = ModeBits'($urandom_range(OP_ADD, OP_DEC));
		req.operand_a  = pick_word();
		req.operand_b  = pick_word();
		req.has_amount = 1'($urandom_range(0, 1));
		// make zero divisors a regular event
		if (req.mode inside {OP_DIV, OP_IDIV, OP_MOD} && $urandom_range(0, 9) == 0)
			req.operand_b = '0;
		return req;
	endfunction

	function automatic bit take_idle();
		return idle_enable && ($urandom_range(0, 99) < IDLE_PCT);
	endfunction

	// Drive one transaction starting at a falling edge; returns at the falling
	// edge after acceptance so the next call owns valid for that step.
	task automatic send_req(alu_req_t req, alu_rsp_t rsp);
		while (take_idle()) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= req;
		do @(posedge clk); while (!in_ch.ready);
		pending_rsp_q.push_back(rsp);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic report_mismatch(string field, logic [WordBits-1:0] want,
			logic [WordBits-1:0] got);
		error_count++;
		$display("%0t mismatch on %s: expected %h got %h", $time, field, want, got);
	endtask

	// ---------------------------------------------------------------------
	// Reset, then directed table, then random traffic
	// ---------------------------------------------------------------------
	initial begin
		alu_req_t req;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		arst_n       = 1'b0;
		idle_enable  = 1'b1;
		stim_done    = 1'b0;
		build_directed();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_req(directed_rows[i].req, directed_rows[i].typed ?
				directed_rows[i].rsp : alu_predict(directed_rows[i].req));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// a quiet window: back-to-back traffic on both channels
			idle_enable = !(n >= 600 && n < 900);
			// hold off until the block has fully drained once
			if (n == 1200) begin
				in_ch.valid <= 1'b0;
				while (pending_rsp_q.size() != 0)
					@(negedge clk);
			end
			req = random_req();
			send_req(req, alu_predict(req));
		end
		in_ch.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// sink side backpressure, changed on the falling edge only
	always @(negedge clk) begin
		out_ch.ready <= arst_n && !take_idle();
	end

	// result checker, sampled on the rising edge
	always @(posedge clk) begin
		alu_rsp_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			rsp_count++;
			if (pending_rsp_q.size() == 0) begin
				report_mismatch("unexpected transaction", '0, out_ch.data.result);
			end else begin
				want = pending_rsp_q.pop_front();
				if (want.bad_arithmetic)
					fault_count++;
				if (out_ch.data.result !== want.result)
					report_mismatch("result", want.result, out_ch.data.result);
				if (out_ch.data.write_back !== want.write_back)
					report_mismatch("write_back", WordBits'(want.write_back),
						WordBits'(out_ch.data.write_back));
				if (out_ch.data.bad_arithmetic !== want.bad_arithmetic)
					report_mismatch("bad_arithmetic", WordBits'(want.bad_arithmetic),
						WordBits'(out_ch.data.bad_arithmetic));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_rsp_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// end of run: drain, settle, verdict
	initial begin
		wait (stim_done);
		while (pending_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d transactions (%0d directed), %0d responses, %0d divide faults",
			sent_count, directed_rows.size(), rsp_count, fault_count);
		$display("all opcodes incl. undefined ones, random stalls on both channels, %0d errors",
			error_count);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
